[rtl/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// rrt_pkg: shared types and constants of the 2D tree grower
// Request/result structs, operation and status codes, fixed-point helpers.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int MAX_NODES_DEF = 16384;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int ROOT_W        = 18;   // integer root of a squared distance
  localparam int DIST_W        = 35;   // sum of two squared axis distances
  localparam int DIFF_W        = 18;   // signed axis difference
  localparam int MAG_W         = 17;   // magnitude of an axis difference
  localparam int SQ_W          = 2 * MAG_W;
  localparam int PROD_W        = 32;   // magnitude times step length
  localparam int DIV_NUM_W     = 33;   // rounded dividend
  localparam int SUM_W         = 35;   // node plus signed quotient

  typedef enum logic [2:0] {
    CFG_START_X     = 3'd0,
    CFG_START_Y     = 3'd1,
    CFG_GOAL_X      = 3'd2,
    CFG_GOAL_Y      = 3'd3,
    CFG_STEP_LENGTH = 3'd4,
    CFG_GOAL_RADIUS = 3'd5,
    CFG_TREE_LIMIT  = 3'd6
  } rrt_cfg_idx_t;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_PATH    = 2'd1,
    OP_RESTART = 2'd2
  } rrt_op_t;

  typedef enum logic [2:0] {
    ST_EXTEND  = 3'd0,
    ST_GOAL    = 3'd1,
    ST_EXHAUST = 3'd2,
    ST_IGNORE  = 3'd3,
    ST_PATH    = 3'd4
  } rrt_status_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] sample_x;
    logic [7:0] sample_y;
  } rrt_req_t;

  typedef struct packed {
    rrt_status_t        status;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [14:0]        node_total;
    logic               path_last;
  } rrt_rsp_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = (v < 0) ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [15:0] r;
    if (v > SUM_W'(32767)) r = 16'sh7FFF;
    else if (v < -SUM_W'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[rtl/rrt_sqrt.sv]
// ----------------------------------------------------------------------------
// rrt_sqrt: iterative integer square root
// Two operand bits per cycle, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module rrt_sqrt #(
  parameter int ROOT_W = rrt_pkg::ROOT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [2*ROOT_W-1:0]   operand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] op_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                active_r;
  logic                done_r;
  logic [REM_W-1:0]    tmp;
  logic [REM_W-1:0]    trial;

  assign tmp   = {rem_r[REM_W-3:0], op_r[2*ROOT_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(ROOT_W);
        op_r     <= operand;
        rem_r    <= '0;
        root_r   <= '0;
      end else if (active_r) begin
        op_r <= op_r << 2;
        if (tmp >= trial) begin
          rem_r  <= tmp - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= tmp;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/rrt_div.sv]
// ----------------------------------------------------------------------------
// rrt_div: iterative restoring divider
// One quotient bit per cycle, unsigned, floor quotient.
// ----------------------------------------------------------------------------
module rrt_div #(
  parameter int NUM_W = rrt_pkg::DIV_NUM_W,
  parameter int DEN_W = rrt_pkg::ROOT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DEN_W-1:0]  denom,
  output logic              done,
  output logic [NUM_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             active_r;
  logic             done_r;
  logic [DEN_W:0]   tmp;
  logic             fits;

  assign tmp  = {rem_r, num_r[NUM_W-1]};
  assign fits = (tmp >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(NUM_W);
        num_r    <= numer;
        den_r    <= denom;
        rem_r    <= '0;
        quot_r   <= '0;
      end else if (active_r) begin
        num_r  <= num_r << 1;
        quot_r <= {quot_r[NUM_W-2:0], fits};
        if (fits) rem_r <= DEN_W'(tmp - {1'b0, den_r});
        else      rem_r <= tmp[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[rtl/rrt_tree_grow_2d_unit.sv]
// ----------------------------------------------------------------------------
// rrt_tree_grow_2d_unit: 2D rapidly-exploring random tree grower
// Sequence: a sample scans the nodes, then runs the square root and a multiply
//   and divide per axis; a goal hit, or a sample that sits on a node, ends at
//   the scan. Path reads pass through the path state; restart, ignored and
//   exhausted requests answer straight from idle.
// Throughput: one request at a time; the scan reads one node per cycle from
//   the single node memory read port and sets the rate. Results cannot be stalled.
// Reset: synchronous, active low; root at the start position, one node,
//   growing phase. The node memory itself is not cleared.
// ----------------------------------------------------------------------------
module rrt_tree_grow_2d_unit #(
  parameter int MAX_NODES = rrt_pkg::MAX_NODES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rrt_pkg::rrt_req_t                  in_req,
  output logic                               out_valid,
  output rrt_pkg::rrt_rsp_t                  out_rsp,
  input  logic                               cfg_we,
  input  logic [rrt_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [rrt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int LW = (CW > 15) ? CW : 15;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [AW-1:0]      parent;
  } node_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SQRT, S_MUL, S_DIV, S_PATH} state_t;
  typedef enum logic [1:0] {PH_GROW, PH_FOUND, PH_EXHAUST} phase_t;

  // --- configuration registers ---------------------------------------------
  logic signed [15:0] start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [14:0]        step_r, radius_r, tlimit_r;
  logic [29:0]        r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= 16'sd12800;
      start_y_r <= 16'sd12800;
      goal_x_r  <= 16'sd23040;
      goal_y_r  <= 16'sd23040;
      step_r    <= 15'd256;
      radius_r  <= 15'd256;
      tlimit_r  <= 15'd10000;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rrt_pkg::CFG_START_X:     start_x_r <= cfg_wdata;
        rrt_pkg::CFG_START_Y:     start_y_r <= cfg_wdata;
        rrt_pkg::CFG_GOAL_X:      goal_x_r  <= cfg_wdata;
        rrt_pkg::CFG_GOAL_Y:      goal_y_r  <= cfg_wdata;
        rrt_pkg::CFG_STEP_LENGTH: step_r    <= cfg_wdata[14:0];
        rrt_pkg::CFG_GOAL_RADIUS: radius_r  <= cfg_wdata[14:0];
        rrt_pkg::CFG_TREE_LIMIT:  tlimit_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // goal radius squared, kept ready for the scan compare
  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
  end

  // --- sequencer state -----------------------------------------------------
  state_t             state_r;
  phase_t             phase_r;
  logic signed [15:0] root_x_r, root_y_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      cursor_r;
  logic [7:0]         samp_x_r, samp_y_r;
  logic [CW-1:0]      rd_idx_r;
  logic               s1_valid_r, s2_valid_r;
  logic [AW-1:0]      s1_idx_r, s2_idx_r;
  logic signed [15:0] s2_x_r, s2_y_r;
  logic [rrt_pkg::SQ_W-1:0]   sqg_x_r, sqg_y_r, sqs_x_r, sqs_y_r;
  logic [rrt_pkg::DIST_W-1:0] best_r;
  logic [AW-1:0]      near_r;
  logic signed [15:0] near_x_r, near_y_r;
  logic               axis_r, neg_r;
  logic [rrt_pkg::PROD_W-1:0] prod_r;
  logic signed [15:0] px_r;
  logic               sqrt_go_r, div_go_r;
  logic               out_valid_r;
  rrt_pkg::rrt_rsp_t  out_rsp_r;

  // --- node memory: one write port, one registered read port ---------------
  node_t         mem [MAX_NODES];
  node_t         rdata_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  node_t         mem_wdata;

  assign rd_addr = (state_r == S_SCAN) ? rd_idx_r[AW-1:0] : cursor_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (mem_we) mem[count_r[AW-1:0]] <= mem_wdata;
  end

  // --- scan datapath ---------------------------------------------------------
  logic signed [15:0] s1_x, s1_y;
  logic signed [rrt_pkg::DIFF_W-1:0] samp_x18, samp_y18;
  logic signed [rrt_pkg::DIFF_W-1:0] dgx, dgy, dsx, dsy;
  logic [rrt_pkg::DIST_W-1:0] g2, d2, fin_best;
  logic        goal_hit, scan_last, scan_end, better;
  logic [AW-1:0]      fin_near;
  logic signed [15:0] fin_x, fin_y, samp_sat_x, samp_sat_y;

  // entry 0 lives in registers so that reset and restart need no write
  assign s1_x = (s1_idx_r == '0) ? root_x_r : rdata_r.x;
  assign s1_y = (s1_idx_r == '0) ? root_y_r : rdata_r.y;

  assign samp_x18 = {2'b00, samp_x_r, 8'h00};
  assign samp_y18 = {2'b00, samp_y_r, 8'h00};
  assign dgx = {{2{goal_x_r[15]}}, goal_x_r} - {{2{s1_x[15]}}, s1_x};
  assign dgy = {{2{goal_y_r[15]}}, goal_y_r} - {{2{s1_y[15]}}, s1_y};
  assign dsx = {{2{s1_x[15]}}, s1_x} - samp_x18;
  assign dsy = {{2{s1_y[15]}}, s1_y} - samp_y18;

  assign g2 = {1'b0, sqg_x_r} + {1'b0, sqg_y_r};
  assign d2 = {1'b0, sqs_x_r} + {1'b0, sqs_y_r};
  assign goal_hit  = s2_valid_r && (g2 < rrt_pkg::DIST_W'(r2_r));
  assign scan_last = (CW'(s2_idx_r) == count_r - 1'b1);
  assign scan_end  = s2_valid_r && !goal_hit && scan_last;
  assign better    = d2 < best_r;
  assign fin_best  = better ? d2 : best_r;
  assign fin_near  = better ? s2_idx_r : near_r;
  assign fin_x     = better ? s2_x_r : near_x_r;
  assign fin_y     = better ? s2_y_r : near_y_r;

  // sample that sits on a node becomes the new node, clipped to Q8.8
  assign samp_sat_x = samp_x_r[7] ? 16'sh7FFF : {1'b0, samp_x_r[6:0], 8'h00};
  assign samp_sat_y = samp_y_r[7] ? 16'sh7FFF : {1'b0, samp_y_r[6:0], 8'h00};

  // --- extension datapath ----------------------------------------------------
  logic                       sqrt_done, div_done;
  logic [rrt_pkg::ROOT_W-1:0] sqrt_root;
  logic [rrt_pkg::DIV_NUM_W-1:0] quot, numer;
  logic signed [rrt_pkg::DIFF_W-1:0] ext_diff;
  logic signed [15:0]         base;
  logic signed [rrt_pkg::SUM_W-1:0] q_signed, new_sum;
  logic signed [15:0]         new_pt;
  logic [rrt_pkg::ROOT_W-1:0] dist_r;

  rrt_sqrt #(.ROOT_W(rrt_pkg::ROOT_W)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (sqrt_go_r),
    .operand ({1'b0, best_r}),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  // round half away from zero: add half the divisor to the magnitude
  assign numer = {1'b0, prod_r} + rrt_pkg::DIV_NUM_W'(dist_r >> 1);

  rrt_div #(.NUM_W(rrt_pkg::DIV_NUM_W), .DEN_W(rrt_pkg::ROOT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .numer (numer),
    .denom (dist_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign ext_diff = axis_r ? (samp_y18 - {{2{near_y_r[15]}}, near_y_r})
                           : (samp_x18 - {{2{near_x_r[15]}}, near_x_r});
  assign base     = axis_r ? near_y_r : near_x_r;
  assign q_signed = neg_r ? -rrt_pkg::SUM_W'(quot) : rrt_pkg::SUM_W'(quot);
  assign new_sum  = rrt_pkg::SUM_W'(base) + q_signed;
  assign new_pt   = rrt_pkg::sat16(new_sum);

  // --- node writes -------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '{x: goal_x_r, y: goal_y_r, parent: s2_idx_r};
    if (state_r == S_SCAN && goal_hit) begin
      mem_we = 1'b1;
    end else if (state_r == S_SCAN && scan_end && fin_best == '0) begin
      mem_we    = 1'b1;
      mem_wdata = '{x: samp_sat_x, y: samp_sat_y, parent: fin_near};
    end else if (state_r == S_DIV && div_done && axis_r) begin
      mem_we    = 1'b1;
      mem_wdata = '{x: px_r, y: new_pt, parent: near_r};
    end
  end

  // --- limit check -------------------------------------------------------------
  logic [LW-1:0] lim_tree, lim_max, lim;
  logic          at_limit;

  assign lim_tree = LW'(tlimit_r);
  assign lim_max  = LW'(MAX_NODES);
  assign lim      = (lim_tree < lim_max) ? lim_tree : lim_max;
  assign at_limit = LW'(count_r) >= lim;

  logic accept;
  assign accept = start && (state_r == S_IDLE);

  // answer for a request that changes nothing
  rrt_pkg::rrt_rsp_t ign_rsp;
  assign ign_rsp = '{status: rrt_pkg::ST_IGNORE, point_x: '0, point_y: '0,
                     node_total: 15'(count_r), path_last: 1'b0};

  // --- sequencer -----------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_GROW;
      root_x_r    <= 16'sd12800;
      root_y_r    <= 16'sd12800;
      count_r     <= CW'(1);
      cursor_r    <= '0;
      rd_idx_r    <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sqrt_go_r   <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      sqrt_go_r   <= 1'b0;
      div_go_r    <= 1'b0;
      // scan pipeline: advance unconditionally, act only while scanning
      s1_valid_r  <= (state_r == S_SCAN) && (rd_idx_r < count_r);
      s1_idx_r    <= rd_idx_r[AW-1:0];
      s2_valid_r  <= (state_r == S_SCAN) && s1_valid_r;
      s2_idx_r    <= s1_idx_r;
      s2_x_r      <= s1_x;
      s2_y_r      <= s1_y;
      sqg_x_r     <= rrt_pkg::mag_of(dgx) * rrt_pkg::mag_of(dgx);
      sqg_y_r     <= rrt_pkg::mag_of(dgy) * rrt_pkg::mag_of(dgy);
      sqs_x_r     <= rrt_pkg::mag_of(dsx) * rrt_pkg::mag_of(dsx);
      sqs_y_r     <= rrt_pkg::mag_of(dsy) * rrt_pkg::mag_of(dsy);

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_req.operation)
              rrt_pkg::OP_SAMPLE: begin
                if (phase_r == PH_FOUND) begin
                  out_valid_r <= 1'b1;
                  out_rsp_r   <= ign_rsp;
                end else if (phase_r == PH_EXHAUST || at_limit) begin
                  phase_r     <= PH_EXHAUST;
                  out_valid_r <= 1'b1;
                  out_rsp_r   <= '{status: rrt_pkg::ST_EXHAUST, point_x: '0, point_y: '0,
                                   node_total: 15'(count_r), path_last: 1'b0};
                end else begin
                  samp_x_r <= in_req.sample_x;
                  samp_y_r <= in_req.sample_y;
                  rd_idx_r <= '0;
                  best_r   <= '1;
                  near_r   <= '0;
                  state_r  <= S_SCAN;
                end
              end
              rrt_pkg::OP_PATH: begin
                // memory read of the cursor entry is under way this cycle
                if (phase_r != PH_FOUND || cursor_r == '0 ||
                    CW'(cursor_r) >= count_r) begin
                  out_valid_r <= 1'b1;
                  out_rsp_r   <= ign_rsp;
                end else begin
                  state_r <= S_PATH;
                end
              end
              rrt_pkg::OP_RESTART: begin
                root_x_r    <= start_x_r;
                root_y_r    <= start_y_r;
                count_r     <= CW'(1);
                phase_r     <= PH_GROW;
                cursor_r    <= '0;
                out_valid_r <= 1'b1;
                out_rsp_r   <= '{status: rrt_pkg::ST_IGNORE, point_x: start_x_r,
                                 point_y: start_y_r, node_total: 15'(1), path_last: 1'b0};
              end
              default: begin
                out_valid_r <= 1'b1;
                out_rsp_r   <= ign_rsp;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (rd_idx_r < count_r) rd_idx_r <= rd_idx_r + 1'b1;
          if (goal_hit) begin
            // first node inside the goal radius: attach the goal and stop
            cursor_r    <= count_r[AW-1:0];
            count_r     <= count_r + 1'b1;
            phase_r     <= PH_FOUND;
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_rsp_r   <= '{status: rrt_pkg::ST_GOAL, point_x: goal_x_r, point_y: goal_y_r,
                             node_total: 15'(count_r + 1'b1), path_last: 1'b0};
          end else if (s2_valid_r) begin
            best_r   <= fin_best;
            near_r   <= fin_near;
            near_x_r <= fin_x;
            near_y_r <= fin_y;
            if (scan_last) begin
              if (fin_best == '0) begin
                count_r     <= count_r + 1'b1;
                state_r     <= S_IDLE;
                out_valid_r <= 1'b1;
                out_rsp_r   <= '{status: rrt_pkg::ST_EXTEND, point_x: samp_sat_x,
                                 point_y: samp_sat_y, node_total: 15'(count_r + 1'b1),
                                 path_last: 1'b0};
              end else begin
                sqrt_go_r <= 1'b1;
                state_r   <= S_SQRT;
              end
            end
          end
        end

        S_SQRT: begin
          if (sqrt_done) begin
            dist_r  <= sqrt_root;
            axis_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end

        S_MUL: begin
          prod_r   <= rrt_pkg::mag_of(ext_diff) * step_r;
          neg_r    <= ext_diff < 0;
          div_go_r <= 1'b1;
          state_r  <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            if (!axis_r) begin
              px_r    <= new_pt;
              axis_r  <= 1'b1;
              state_r <= S_MUL;
            end else begin
              count_r     <= count_r + 1'b1;
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              out_rsp_r   <= '{status: rrt_pkg::ST_EXTEND, point_x: px_r, point_y: new_pt,
                               node_total: 15'(count_r + 1'b1), path_last: 1'b0};
            end
          end
        end

        S_PATH: begin
          // hand out the cursor node and step to its parent
          cursor_r    <= rdata_r.parent;
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_rsp_r   <= '{status: rrt_pkg::ST_PATH, point_x: rdata_r.x, point_y: rdata_r.y,
                           node_total: 15'(count_r), path_last: (rdata_r.parent == '0)};
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

[rtl/rrt_chk.sv]
// ----------------------------------------------------------------------------
// rrt_chk: port-level checks of the tree grower
// Watches the request and result ports and flags illegal result patterns.
// ----------------------------------------------------------------------------
module rrt_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rrt_pkg::rrt_rsp_t out_rsp
);

  // a request that starts a long job produces no result in its first cycle
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result seen as the unit turned busy");

  // a result that does not end a busy job always answers an accepted request
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(busy) |-> $past(start))
    else $error("result without a request");

  a_last_only_on_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != rrt_pkg::ST_PATH |-> !out_rsp.path_last)
    else $error("path_last set outside a path point");

  a_exhaust_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == rrt_pkg::ST_EXHAUST
      |-> out_rsp.point_x == '0 && out_rsp.point_y == '0 && !busy)
    else $error("exhausted result carries a point");

endmodule

bind rrt_tree_grow_2d_unit rrt_chk u_rrt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
